>>> src/pcas_pkg.sv
// Shared types and codes for the polygon angle sort block.
package pcas_pkg;

	localparam int QDEPTH = 4;

	localparam logic [1:0] CLS_LOW  = 2'd0;
	localparam logic [1:0] CLS_ZERO = 2'd1;
	localparam logic [1:0] CLS_UP   = 2'd2;
	localparam logic [1:0] CLS_PI   = 2'd3;

	typedef struct packed {
		logic last;
		logic store;
	} vflags_t;

	typedef struct packed {
		logic loading;
		logic emitting;
	} bstat_t;

	typedef enum logic [3:0] {
		B_LOAD,
		B_FI,
		B_WI,
		B_SCAN,
		B_DRAIN,
		B_E1,
		B_E2,
		B_E3,
		B_OUT
	} bst_t;

endpackage

>>> src/pcas_front.sv
// Input side: accepts vertex transfers and marks each one stored or dropped.
module pcas_front #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COORD_BITS-1:0] in_x,
	input  logic signed [COORD_BITS-1:0] in_y,
	input  logic                         in_last,
	output logic                         push,
	input  logic                         q_full,
	output logic [2*COORD_BITS+1:0]      push_data
);
	import pcas_pkg::*;

	localparam int CNTW = $clog2(MAX_VERTICES + 1);

	logic [CNTW-1:0] cnt_q;
	vflags_t         flg;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		flg.last  = in_last;
		flg.store = cnt_q < CNTW'(MAX_VERTICES);
	end

	assign push_data = {flg, in_y, in_x};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			if (in_last) begin
				cnt_q <= '0;
			end else if (flg.store) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

endmodule

>>> src/pcas_fifo.sv
// Short queue between the input side and the sort engine.
module pcas_fifo #(
	parameter int W = 34
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         full,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] pop_data
);
	import pcas_pkg::*;

	localparam int PW = $clog2(QDEPTH);

	logic [W-1:0]  mem_q [QDEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [PW:0]   cnt_q;

	assign full      = cnt_q == (PW+1)'(QDEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_data  = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push && !full) begin
				wp_q <= wp_q + 1'b1;
			end
			if (pop && not_empty) begin
				rp_q <= rp_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(push && !full) - (PW+1)'(pop && not_empty);
		end
	end

endmodule

>>> src/pcas_back.sv
// Sort engine: stores vertices, ranks them by angle about the centroid, emits in order.
module pcas_back #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	output logic                         pop,
	input  logic [2*COORD_BITS+1:0]      q_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic signed [COORD_BITS-1:0] out_x,
	output logic signed [COORD_BITS-1:0] out_y,
	output logic                         out_last,
	output logic                         out_ovf,
	output pcas_pkg::bstat_t             stat
);
	import pcas_pkg::*;

	localparam int CB   = COORD_BITS;
	localparam int CNTW = $clog2(MAX_VERTICES + 1);
	localparam int AW   = $clog2(MAX_VERTICES);
	localparam int SUMW = CB + CNTW;
	localparam int DW   = CB + CNTW + 1;
	localparam int PW   = 2 * DW;

	function automatic logic [1:0] half_cls(input logic signed [DW-1:0] dx,
		input logic signed [DW-1:0] dy);
		logic [1:0] c;
		if (dy < 0) begin
			c = CLS_LOW;
		end else if (dy == 0 && dx >= 0) begin
			c = CLS_ZERO;
		end else if (dy > 0) begin
			c = CLS_UP;
		end else begin
			c = CLS_PI;
		end
		return c;
	endfunction

	bst_t state_q, state_d;

	logic signed [CB-1:0] mem_x [MAX_VERTICES];
	logic signed [CB-1:0] mem_y [MAX_VERTICES];
	logic [AW-1:0]        ord_mem [MAX_VERTICES];

	logic signed [CB-1:0]   qx, qy;
	vflags_t                qf;
	logic signed [SUMW-1:0] sum_x_q, sum_y_q;
	logic [CNTW-1:0]        n_q, i_q, j_q, k_q, rank_q;
	logic                   drop_q;
	logic [AW-1:0]          raddr;
	logic signed [CB-1:0]   rd_x_q, rd_y_q;
	logic [AW-1:0]          ord_rd_q;
	logic                   issue, issue_fetch;

	logic                 v_s1, tag_s1, jlt_s1;
	logic                 v_s2, tag_s2, jlt_s2;
	logic signed [DW-1:0] dx_s2, dy_s2;
	logic signed [DW-1:0] dxi_q, dyi_q;
	logic [1:0]           ci_q;
	logic                 v_s3, jlt_s3;
	logic [1:0]           cj_s3;
	logic signed [PW-1:0] p1_s3, p2_s3;

	logic signed [DW-1:0] n_s, dx_c, dy_c, nx, ny;
	logic signed [PW:0]   crs;
	logic                 less_ji, tie, hit;

	assign {qf, qy, qx} = q_data;

	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		issue       = 1'b0;
		issue_fetch = 1'b0;
		raddr       = '0;
		unique case (state_q)
			B_LOAD: begin
				pop = q_valid;
				if (q_valid && qf.last) begin
					state_d = B_FI;
				end
			end
			B_FI: begin
				raddr       = i_q[AW-1:0];
				issue       = 1'b1;
				issue_fetch = 1'b1;
				state_d     = B_WI;
			end
			B_WI: begin
				if (v_s2 && tag_s2) begin
					state_d = B_SCAN;
				end
			end
			B_SCAN: begin
				raddr = j_q[AW-1:0];
				issue = 1'b1;
				if (j_q == n_q - 1'b1) begin
					state_d = B_DRAIN;
				end
			end
			B_DRAIN: begin
				if (!v_s1 && !v_s2 && !v_s3) begin
					state_d = (i_q == n_q - 1'b1) ? B_E1 : B_FI;
				end
			end
			B_E1: state_d = B_E2;
			B_E2: begin
				raddr   = ord_rd_q;
				state_d = B_E3;
			end
			B_E3: begin
				raddr   = ord_rd_q;
				state_d = B_OUT;
			end
			B_OUT: begin
				raddr = ord_rd_q;
				if (out_ready) begin
					state_d = out_last ? B_LOAD : B_E1;
				end
			end
			default: state_d = B_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && qf.store) begin
			mem_x[n_q[AW-1:0]] <= qx;
			mem_y[n_q[AW-1:0]] <= qy;
		end
		rd_x_q <= mem_x[raddr];
		rd_y_q <= mem_y[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == B_DRAIN && state_d != B_DRAIN) begin
			ord_mem[rank_q[AW-1:0]] <= i_q[AW-1:0];
		end
		ord_rd_q <= ord_mem[k_q[AW-1:0]];
	end

	// distance vector scaled by n: n*v - sum
	always_comb begin
		n_s  = DW'(n_q);
		nx   = DW'(n_s * DW'(rd_x_q));
		ny   = DW'(n_s * DW'(rd_y_q));
		dx_c = nx - DW'(sum_x_q);
		dy_c = ny - DW'(sum_y_q);
	end

	always_comb begin
		crs     = (PW+1)'(p1_s3) - (PW+1)'(p2_s3);
		less_ji = (cj_s3 < ci_q) ||
			(cj_s3 == ci_q && (cj_s3 == CLS_LOW || cj_s3 == CLS_UP) && crs > 0);
		tie     = cj_s3 == ci_q &&
			(cj_s3 == CLS_ZERO || cj_s3 == CLS_PI || crs == 0);
		hit     = less_ji || (tie && jlt_s3);
	end

	always_ff @(posedge clk) begin
		dx_s2 <= dx_c;
		dy_s2 <= dy_c;
		p1_s3 <= PW'(dx_s2) * PW'(dyi_q);
		p2_s3 <= PW'(dy_s2) * PW'(dxi_q);
		cj_s3 <= half_cls(dx_s2, dy_s2);
		if (state_q == B_WI && v_s2 && tag_s2) begin
			dxi_q <= dx_s2;
			dyi_q <= dy_s2;
			ci_q  <= half_cls(dx_s2, dy_s2);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			tag_s1  <= 1'b0;
			jlt_s1  <= 1'b0;
			v_s2    <= 1'b0;
			tag_s2  <= 1'b0;
			jlt_s2  <= 1'b0;
			v_s3    <= 1'b0;
			jlt_s3  <= 1'b0;
			sum_x_q <= '0;
			sum_y_q <= '0;
			n_q     <= '0;
			drop_q  <= 1'b0;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
			rank_q  <= '0;
		end else begin
			v_s1   <= issue;
			tag_s1 <= issue_fetch;
			jlt_s1 <= j_q < i_q;
			v_s2   <= v_s1;
			tag_s2 <= tag_s1;
			jlt_s2 <= jlt_s1;
			v_s3   <= v_s2 && !tag_s2;
			jlt_s3 <= jlt_s2;
			if (v_s3 && hit) begin
				rank_q <= rank_q + 1'b1;
			end
			unique case (state_q)
				B_LOAD: begin
					i_q <= '0;
					if (pop) begin
						if (qf.store) begin
							sum_x_q <= sum_x_q + SUMW'(qx);
							sum_y_q <= sum_y_q + SUMW'(qy);
							n_q     <= n_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
					end
				end
				B_WI: begin
					j_q    <= '0;
					rank_q <= '0;
				end
				B_SCAN: j_q <= j_q + 1'b1;
				B_DRAIN: begin
					if (state_d != B_DRAIN) begin
						i_q <= i_q + 1'b1;
						k_q <= '0;
					end
				end
				B_OUT: begin
					if (out_ready) begin
						k_q <= k_q + 1'b1;
						if (out_last) begin
							sum_x_q <= '0;
							sum_y_q <= '0;
							n_q     <= '0;
							drop_q  <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	assign out_valid     = state_q == B_OUT;
	assign out_x         = rd_x_q;
	assign out_y         = rd_y_q;
	assign out_last      = k_q == n_q - 1'b1;
	assign out_ovf       = drop_q;
	assign stat.loading  = state_q == B_LOAD;
	assign stat.emitting = state_q == B_OUT;

endmodule

>>> src/polygon_ccw_angle_sort.sv
// Top level of the polygon counterclockwise angle sort block.
//
// Vertices of one polygon arrive on the s_axis channel, one transfer each,
// with tlast on the final vertex. Up to MAX_VERTICES are stored; later ones
// are dropped and reported on every result through m_axis_tuser.
// After the final vertex the stored vertices leave on m_axis in ascending
// angle about the centroid over (-pi, pi], equal angles in load order, with
// tlast on the last one.
// Vertices load through a four-entry queue, so the input keeps taking
// transfers while a sort runs until that queue fills. Each vertex is
// ranked by comparing it against all others through one read port of the
// vertex store and one pipelined cross-product unit. Each result then
// passes through states B_E1, B_E2, B_E3 and B_OUT and waits in B_OUT
// while the receiver holds tready low; m_axis_tvalid and the payload
// stay put until the transfer completes.
// Reset clears counts, sums, the queue and the state; the vertex store keeps
// no reset value and needs no clearing pass.
module polygon_ccw_angle_sort #(
	parameter int MAX_VERTICES = 64,
	parameter int COORD_BITS   = 16
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [((2*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,  // vertex_x, vertex_y
	input  logic                                s_axis_tlast,  // vertex_last
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [((2*COORD_BITS+7)/8)*8-1:0]   m_axis_tdata,  // sorted_x, sorted_y
	output logic                                m_axis_tlast,  // sorted_last
	output logic                                m_axis_tuser   // overflow_seen
);
	import pcas_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int DBW = ((2*CB+7)/8)*8;
	localparam int QW  = 2*CB + 2;

	logic            push, q_full, pop, q_valid;
	logic [QW-1:0]   push_data, q_data;
	logic signed [CB-1:0] ox, oy;
	bstat_t          stat;

	pcas_front #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(CB)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_x      (s_axis_tdata[CB-1:0]),
		.in_y      (s_axis_tdata[2*CB-1:CB]),
		.in_last   (s_axis_tlast),
		.push      (push),
		.q_full    (q_full),
		.push_data (push_data)
	);

	pcas_fifo #(.W(QW)) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	pcas_back #(.MAX_VERTICES(MAX_VERTICES), .COORD_BITS(CB)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.pop       (pop),
		.q_data    (q_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_x     (ox),
		.out_y     (oy),
		.out_last  (m_axis_tlast),
		.out_ovf   (m_axis_tuser),
		.stat      (stat)
	);

	assign m_axis_tdata = DBW'({oy, ox});

	a_out_only_emitting: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> stat.emitting) else $error("output valid outside emit");

	a_pop_only_loading: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> stat.loading) else $error("queue popped while sorting");

	a_back_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> stat.loading)
		else $error("engine not back to loading after final result");

endmodule
